// File: rtl/rimsk_pkg.sv
// Shared constants, types and helpers for the received-ID window block.
package rimsk_pkg;

    localparam int unsigned RIM_WINDOW    = 16;
    localparam int unsigned RIM_REMOTES   = 8;
    localparam int unsigned RIM_MASK_BITS = 16;
    localparam int unsigned RIM_Q_DEPTH   = 2;

    localparam int unsigned ID_W      = 32;
    localparam int unsigned SLOT_IN_W = 3;
    localparam int unsigned ACK_W     = 16;
    localparam int unsigned ACK_IW    = 4;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_META,
        BK_SCAN,
        BK_WRITE,
        BK_MASK,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic              seen_before;
        logic [ACK_W-1:0]  ack_mask;
        logic [ID_W-1:0]   highest_id;
    } res_t;

    // Reduce a raw slot number modulo the remote count by repeated subtraction.
    function automatic logic [5:0] reduce_slot(input logic [SLOT_IN_W-1:0] v,
                                               input int unsigned r);
        logic [6:0] acc;
        logic [6:0] rr;
        acc = {4'b0000, v};
        rr  = r[6:0];
        for (int i = 0; i < 8; i++) begin
            if (acc >= rr) begin
                acc = acc - rr;
            end
        end
        return acc[5:0];
    endfunction

endpackage

// File: rtl/received_id_window_ack_mask_top.sv
// Top level of the received-ID window and ack mask block.
//
// Push side: drive remote_slot and packet_id with push high; the packet is
// taken on a rising edge where push is high and full is low. Slots past the
// last remote wrap around modulo REMOTES.
// Result side: while empty is low, seen_before, ack_mask and highest_id show
// the oldest result; pop it with pop high on a rising edge.
// Each packet yields exactly one result, in arrival order.
// Processing: the engine reads the remote's fill count, scans the n entries
// held before the insert for a duplicate, writes the packet, then walks the m
// entries held after it to build the ack mask; an empty window skips the
// duplicate scan.
// The engine takes one packet at a time and takes the next only after the
// result of the last one is queued. It is bound by the single read port of the
// ID memory, which is walked once for the duplicate check and once more for
// the ack mask.
// Reset: clears every window to empty and both queues; the ID memory itself
// is not cleared, only entries covered by a window's fill count are read.
// Stall: a held result parks in a two-entry output queue; the engine waits
// behind it, then the two-entry input queue fills and full rises.
module received_id_window_ack_mask_top
    import rimsk_pkg::*;
#(
    parameter int unsigned WINDOW    = RIM_WINDOW,
    parameter int unsigned REMOTES   = RIM_REMOTES,
    parameter int unsigned MASK_BITS = RIM_MASK_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [SLOT_IN_W-1:0] remote_slot,
    input  logic [ID_W-1:0]      packet_id,
    output logic                 empty,
    input  logic                 pop,
    output logic                 seen_before,
    output logic [ACK_W-1:0]     ack_mask,
    output logic [ID_W-1:0]      highest_id
);

    localparam int unsigned SW = (REMOTES > 1) ? $clog2(REMOTES) : 1;

    logic            cmd_valid;
    logic            cmd_pop;
    logic [SW-1:0]   cmd_slot;
    logic [ID_W-1:0] cmd_id;
    logic            res_full;
    logic            res_push;
    res_t            res_in;
    res_t            res_out;

    // Accept and queue incoming packets
    rimsk_front #(
        .REMOTES (REMOTES),
        .SW      (SW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .remote_slot (remote_slot),
        .packet_id   (packet_id),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd_slot    (cmd_slot),
        .cmd_id      (cmd_id)
    );

    // Check, insert and build the ack mask, one packet at a time
    rimsk_back #(
        .WINDOW    (WINDOW),
        .REMOTES   (REMOTES),
        .MASK_BITS (MASK_BITS),
        .SW        (SW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_slot  (cmd_slot),
        .cmd_id    (cmd_id),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    // Hold finished results until the receiver takes them
    rimsk_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RIM_Q_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign seen_before = res_out.seen_before;
    assign ack_mask    = res_out.ack_mask;
    assign highest_id  = res_out.highest_id;

endmodule

// File: rtl/rimsk_fifo.sv
// Small synchronous queue with full and empty flags.
module rimsk_fifo
    import rimsk_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = RIM_Q_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/rimsk_front.sv
// Front end: accept packets, fold the slot onto the remote range, queue them.
module rimsk_front
    import rimsk_pkg::*;
#(
    parameter int unsigned REMOTES = RIM_REMOTES,
    parameter int unsigned SW      = (REMOTES > 1) ? $clog2(REMOTES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [SLOT_IN_W-1:0] remote_slot,
    input  logic [ID_W-1:0]      packet_id,
    output logic                 cmd_valid,
    input  logic                 cmd_pop,
    output logic [SW-1:0]        cmd_slot,
    output logic [ID_W-1:0]      cmd_id
);

    logic [5:0]         slot_red;
    logic [SW+ID_W-1:0] cmd_data;
    logic               cmd_empty;

    // Slots past the last remote wrap around onto the remote range
    assign slot_red = reduce_slot(remote_slot, REMOTES);

    rimsk_fifo #(
        .WIDTH (SW + ID_W),
        .DEPTH (RIM_Q_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({slot_red[SW-1:0], packet_id}),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_data),
        .empty   (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;
    assign cmd_slot  = cmd_data[SW+ID_W-1:ID_W];
    assign cmd_id    = cmd_data[ID_W-1:0];

endmodule

// File: rtl/rimsk_back.sv
// Back end: per-remote ID window memory, duplicate check, insert and ack mask scan.
module rimsk_back
    import rimsk_pkg::*;
#(
    parameter int unsigned WINDOW    = RIM_WINDOW,
    parameter int unsigned REMOTES   = RIM_REMOTES,
    parameter int unsigned MASK_BITS = RIM_MASK_BITS,
    parameter int unsigned SW        = (REMOTES > 1) ? $clog2(REMOTES) : 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_pop,
    input  logic [SW-1:0]   cmd_slot,
    input  logic [ID_W-1:0] cmd_id,
    input  logic            res_full,
    output logic            res_push,
    output res_t            res_data
);

    localparam int unsigned PW    = $clog2(WINDOW);
    localparam int unsigned CW    = $clog2(WINDOW + 1);
    localparam int unsigned MW    = CW + PW;
    localparam int unsigned AW    = SW + PW;
    localparam int unsigned DEPTH = REMOTES * (1 << PW);
    localparam int unsigned MB    = (MASK_BITS < ACK_W) ? MASK_BITS : ACK_W;

    // ID memory, one row of 2^PW words per remote
    logic [ID_W-1:0]    id_mem [DEPTH];
    // Fill count and oldest position per remote; valid bits stand for reset
    logic [MW-1:0]      meta_mem [REMOTES];
    logic [REMOTES-1:0] meta_vld_reg;
    logic [REMOTES-1:0] meta_vld_next;
    logic [MW-1:0]      meta_rd_reg;
    logic               meta_hit_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [SW-1:0]      slot_reg;
    logic [SW-1:0]      slot_next;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [PW-1:0]      oldest_reg;
    logic [PW-1:0]      oldest_next;
    logic [CW-1:0]      issue_reg;
    logic [CW-1:0]      issue_next;
    logic [CW-1:0]      got_reg;
    logic [CW-1:0]      got_next;
    logic               eq_reg;
    logic               eq_next;
    logic               allgt_reg;
    logic               allgt_next;
    logic               seen_reg;
    logic               seen_next;
    logic [ID_W-1:0]    high_reg;
    logic [ID_W-1:0]    high_next;
    logic [ACK_W-1:0]   mask_reg;
    logic [ACK_W-1:0]   mask_next;

    logic               rd_vld_reg;
    logic [PW-1:0]      rd_pos_reg;
    logic [ID_W-1:0]    rd_data_reg;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               meta_rd_en;
    logic               meta_wr_en;
    logic               win_full;
    logic [PW-1:0]      wr_pos;
    logic [CW-1:0]      new_count;
    logic [PW-1:0]      new_oldest;
    logic [ID_W-1:0]    id_gap;

    assign win_full   = (count_reg == CW'(WINDOW));
    assign wr_pos     = win_full ? oldest_reg : count_reg[PW-1:0];
    assign new_count  = win_full ? count_reg : count_reg + 1'b1;
    assign new_oldest = !win_full ? oldest_reg :
                        (oldest_reg == PW'(WINDOW - 1)) ? '0 : oldest_reg + 1'b1;
    assign id_gap     = high_reg - rd_data_reg;
    assign rd_addr    = {slot_reg, issue_reg[PW-1:0]};
    assign wr_addr    = {slot_reg, wr_pos};

    assign res_data.seen_before = seen_reg;
    assign res_data.ack_mask    = mask_reg;
    assign res_data.highest_id  = high_reg;

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        id_next       = id_reg;
        count_next    = count_reg;
        oldest_next   = oldest_reg;
        issue_next    = issue_reg;
        got_next      = got_reg;
        eq_next       = eq_reg;
        allgt_next    = allgt_reg;
        seen_next     = seen_reg;
        high_next     = high_reg;
        mask_next     = mask_reg;
        meta_vld_next = meta_vld_reg;
        cmd_pop       = 1'b0;
        meta_rd_en    = 1'b0;
        meta_wr_en    = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        res_push      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    meta_rd_en = 1'b1;
                    slot_next  = cmd_slot;
                    id_next    = cmd_id;
                    state_next = BK_META;
                end
            end
            BK_META:
            begin
                // An untouched remote has an empty window
                count_next  = meta_hit_reg ? meta_rd_reg[MW-1:PW] : '0;
                oldest_next = meta_hit_reg ? meta_rd_reg[PW-1:0] : '0;
                issue_next  = '0;
                got_next    = '0;
                eq_next     = 1'b0;
                allgt_next  = 1'b1;
                high_next   = id_reg;
                mask_next   = '0;
                if (count_next == '0)
                begin
                    state_next = BK_WRITE;
                end
                else
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                // Issue one read per cycle, fold in the word read the cycle before
                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    got_next = got_reg + 1'b1;
                    if (rd_data_reg == id_reg)
                    begin
                        eq_next = 1'b1;
                    end
                    if (rd_data_reg <= id_reg)
                    begin
                        allgt_next = 1'b0;
                    end
                    // Skip the entry about to be evicted when tracking the maximum
                    if (!(win_full && (rd_pos_reg == oldest_reg)) &&
                        (rd_data_reg > high_reg))
                    begin
                        high_next = rd_data_reg;
                    end
                    if (got_next == count_reg)
                    begin
                        state_next = BK_WRITE;
                    end
                end
            end
            BK_WRITE:
            begin
                wr_en      = 1'b1;
                meta_wr_en = 1'b1;
                meta_vld_next[slot_reg] = 1'b1;
                seen_next   = (count_reg != '0) && (eq_reg || allgt_reg);
                count_next  = new_count;
                oldest_next = new_oldest;
                issue_next  = '0;
                got_next    = '0;
                state_next  = BK_MASK;
            end
            BK_MASK:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    got_next = got_reg + 1'b1;
                    if (id_gap < ID_W'(MB))
                    begin
                        mask_next[id_gap[ACK_IW-1:0]] = 1'b1;
                    end
                    if (got_next == count_reg)
                    begin
                        state_next = BK_DONE;
                    end
                end
            end
            BK_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            meta_vld_reg <= '0;
            meta_hit_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            meta_vld_reg <= meta_vld_next;
            rd_vld_reg   <= rd_en;
            if (meta_rd_en)
            begin
                meta_hit_reg <= meta_vld_reg[cmd_slot];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        id_reg     <= id_next;
        count_reg  <= count_next;
        oldest_reg <= oldest_next;
        issue_reg  <= issue_next;
        got_reg    <= got_next;
        eq_reg     <= eq_next;
        allgt_reg  <= allgt_next;
        seen_reg   <= seen_next;
        high_reg   <= high_next;
        mask_reg   <= mask_next;
        rd_pos_reg <= issue_reg[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr] <= id_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= id_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_wr_en)
        begin
            meta_mem[slot_reg] <= {new_count, new_oldest};
        end
        if (meta_rd_en)
        begin
            meta_rd_reg <= meta_mem[cmd_slot];
        end
    end

endmodule

// File: rtl/rimsk_check.sv
// Port-level checker for the received-ID window block, bound to the top level.
module rimsk_check
    import rimsk_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic                 seen_before,
    input logic [ACK_W-1:0]     ack_mask,
    input logic [ID_W-1:0]      highest_id
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // The highest held ID is always in the window, so mask bit zero is set
    a_mask_self: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ack_mask[0])
        else $error("result without ack bit zero");

    // No result shows up unless a packet was taken for it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pend_reg != 8'd0))
        else $error("result with no packet outstanding");

    // Coming out of reset both queues are empty
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // A stalled result holds its fields
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(seen_before) &&
                              $stable(ack_mask) && $stable(highest_id)))
        else $error("stalled result changed");

endmodule

bind received_id_window_ack_mask_top rimsk_check u_check (.*);

// File: dv/rim_ack_checker.sv
// Window predictor and result comparator for the received-ID ack mask block.
module rim_ack_checker
    import rimsk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [SLOT_IN_W-1:0] remote_slot,
    input  logic [ID_W-1:0]      packet_id,
    input  logic                 empty,
    input  logic                 pop,
    input  logic                 seen_before,
    input  logic [ACK_W-1:0]     ack_mask,
    input  logic [ID_W-1:0]      highest_id,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ID_W-1:0] held_ids  [RIM_REMOTES][RIM_WINDOW];
    logic [4:0]      fill_of   [RIM_REMOTES];
    logic [3:0]      oldest_of [RIM_REMOTES];
    res_t            due_acks  [$];
    res_t            head;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                   input logic [ID_W-1:0] want);
        $display("%0t ns mismatch, %s: got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Judge the packet against its remote's window, insert it, then build the ack.
    function automatic res_t admit_packet(input logic [SLOT_IN_W-1:0] slot_raw,
                                          input logic [ID_W-1:0] id);
        int unsigned     s;
        int unsigned     cnt;
        int unsigned     old;
        int unsigned     k;
        int unsigned     j;
        logic [ID_W-1:0] lowest;
        logic [ID_W-1:0] top_id;
        logic [ID_W-1:0] probe;
        res_t            r;
        s   = slot_raw % RIM_REMOTES;
        cnt = fill_of[s];
        old = oldest_of[s];
        r   = '0;
        if (cnt > RIM_WINDOW)
            cnt = RIM_WINDOW;
        if (old >= RIM_WINDOW)
            old = 0;
        if (cnt > 0)
        begin
            lowest = held_ids[s][0];
            for (k = 1; k < cnt; k++)
                if (held_ids[s][k] < lowest)
                    lowest = held_ids[s][k];
            if (id < lowest)
                r.seen_before = 1'b1;
            for (k = 0; k < cnt; k++)
                if (held_ids[s][k] == id)
                    r.seen_before = 1'b1;
        end
        if (cnt < RIM_WINDOW)
        begin
            held_ids[s][(old + cnt) % RIM_WINDOW] = id;
            cnt++;
        end
        else
        begin
            held_ids[s][old] = id;
            old = (old + 1) % RIM_WINDOW;
        end
        fill_of[s]   = 5'(cnt);
        oldest_of[s] = 4'(old);
        top_id = held_ids[s][0];
        for (k = 1; k < cnt; k++)
            if (held_ids[s][k] > top_id)
                top_id = held_ids[s][k];
        for (k = 0; k < RIM_MASK_BITS && k < ACK_W; k++)
        begin
            probe = top_id - ID_W'(k);
            for (j = 0; j < cnt; j++)
                if (held_ids[s][j] == probe)
                    r.ack_mask[k] = 1'b1;
        end
        r.highest_id = top_id;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (fill_of[s])
            begin
                fill_of[s]   = '0;
                oldest_of[s] = '0;
            end
            due_acks.delete();
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (due_acks.size() == 0)
                    report_mismatch("result with nothing expected", highest_id, '0);
                else
                begin
                    head = due_acks.pop_front();
                    if (seen_before !== head.seen_before)
                        report_mismatch("seen_before", ID_W'(seen_before),
                                        ID_W'(head.seen_before));
                    if (ack_mask !== head.ack_mask)
                        report_mismatch("ack_mask", ID_W'(ack_mask), ID_W'(head.ack_mask));
                    if (highest_id !== head.highest_id)
                        report_mismatch("highest_id", highest_id, head.highest_id);
                end
            end
            if (push && !full)
                due_acks.insert(due_acks.size(), admit_packet(remote_slot, packet_id));
            outstanding <= due_acks.size();
        end
    end

endmodule

// File: dv/received_id_window_ack_mask_top_tb.sv
// Stimulus and verdict for the received-ID window and ack mask block.
module received_id_window_ack_mask_top_tb
    import rimsk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Random packets per phase; five phases make up the random part.
    localparam int ITEMS_PER_PHASE = 150;
    // Long receiver hold-off used to back the block up until full rises.
    localparam int HOLD_CYCLES     = 400;
    // Cycles without any transfer before the run is declared hung. The worst
    // correct gap is the hold-off plus the processing of one full-window packet.
    localparam int QUIET_LIMIT     = 4000;
    // Settle time after the last result: one full-window latency and margin.
    localparam int DRAIN_CYCLES    = 2 * RIM_WINDOW + 16;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [SLOT_IN_W-1:0] remote_slot;
    logic [ID_W-1:0]      packet_id;
    logic                 empty;
    logic                 pop;
    logic                 seen_before;
    logic [ACK_W-1:0]     ack_mask;
    logic [ID_W-1:0]      highest_id;

    int                   mismatches;
    int                   outstanding;

    // Knobs set by the sender; the receiver process also reads pop_stall_pct and hold_requests.
    int                   send_idle_pct;
    int                   pop_stall_pct;
    int                   hold_requests;

    // Running sequence number per remote, so most traffic looks like a real
    // packet stream: in order with small gaps, some late, some duplicated.
    logic [ID_W-1:0]      next_seq [RIM_REMOTES];

    received_id_window_ack_mask_top uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .remote_slot (remote_slot),
        .packet_id   (packet_id),
        .empty       (empty),
        .pop         (pop),
        .seen_before (seen_before),
        .ack_mask    (ack_mask),
        .highest_id  (highest_id)
    );

    rim_ack_checker ack_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .remote_slot (remote_slot),
        .packet_id   (packet_id),
        .empty       (empty),
        .pop         (pop),
        .seen_before (seen_before),
        .ack_mask    (ack_mask),
        .highest_id  (highest_id),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one packet and hold it until the transfer happens. Idle gaps go
    // in front of the packet, so push drops only when a gap is taken and a
    // back-to-back packet keeps push high without a glitch.
    task automatic send_packet(input logic [SLOT_IN_W-1:0] slot, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        remote_slot <= slot;
        packet_id   <= id;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Sender: reset, directed packets, then the random phases.
    initial
    begin
        int unsigned          hot_slot;
        int unsigned          pick;
        logic [SLOT_IN_W-1:0] slot;
        logic [ID_W-1:0]      id;

        push          <= 1'b0;
        remote_slot   <= '0;
        packet_id     <= '0;
        rst_n         <= 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_requests = 0;
        hot_slot      = 0;

        // Start some streams low, some just under the wrap, some anywhere.
        foreach (next_seq[s])
        begin
            case ($urandom_range(2))
                0:       next_seq[s] = ID_W'($urandom_range(40));
                1:       next_seq[s] = 32'hFFFF_FFFF - ID_W'($urandom_range(40));
                default: next_seq[s] = $urandom();
            endcase
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty window, then an exact duplicate, then the top of the ID range.
        send_packet(3'd0, 32'h0000_0000);
        send_packet(3'd0, 32'h0000_0000);
        send_packet(3'd0, 32'hFFFF_FFFF);
        send_packet(3'd0, 32'hFFFF_FFFE);
        send_packet(3'd0, 32'h0000_0005);
        // Highest slot: a packet below the window minimum, then a fresh one.
        send_packet(3'd7, 32'd100);
        send_packet(3'd7, 32'd99);
        send_packet(3'd7, 32'd101);
        // Fill one window past WINDOW entries so the oldest is evicted.
        for (int n = 0; n <= RIM_WINDOW; n++)
            send_packet(3'd3, ID_W'(1000 + n));

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    pop_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 45;
                end
                3:
                begin
                    send_idle_pct = 13;
                    pop_stall_pct = 13;
                end
                default:
                begin
                    // Hold the result side off while packets keep coming.
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                    hold_requests++;
                end
            endcase

            repeat (ITEMS_PER_PHASE)
            begin
                // Dwell on one remote for a while so its window fills and wraps.
                if ($urandom_range(24) == 0)
                    hot_slot = $urandom_range(7);
                slot = ($urandom_range(3) == 0) ? SLOT_IN_W'($urandom_range(7))
                                                : SLOT_IN_W'(hot_slot);
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    id            = next_seq[slot];
                    next_seq[slot] = next_seq[slot] + ID_W'($urandom_range(1, 3));
                end
                else if (pick < 70)
                    id = next_seq[slot] - ID_W'($urandom_range(1, 24));
                else if (pick < 80)
                    id = next_seq[slot] + ID_W'($urandom_range(0, 20));
                else if (pick < 90)
                    id = $urandom();
                else if (pick < 95)
                    id = ID_W'($urandom_range(15));
                else
                    id = ~ID_W'($urandom_range(15));
                send_packet(slot, id);
            end
        end

        // Drop push and drain with the receiver always ready.
        push          <= 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial
    begin
        int served;
        int hold_left;

        served    = 0;
        hold_left = 0;
        pop       <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_requests)
            begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
                pop <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Watchdog: advance a quiet counter on every edge without a transfer.
    initial
    begin
        int quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule
